// ===== hw/rtl/nts_pkg.sv =====
// nts_pkg: shared types, constants and the glyph table for number_to_seven_segment
// used by nts_ctrl, nts_dpath and number_to_seven_segment; no dependencies
package nts_pkg;

   typedef struct packed {
      logic [15:0] magnitude;
      logic [4:0]  radix;
      logic        is_negative;
      logic        show_leading_zeros;
      logic [7:0]  dot_mask;
      logic [2:0]  field_length;
      logic [1:0]  start_position;
   } req_type;

   typedef struct packed {
      logic [1:0] position;
      logic [7:0] segments;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_STORE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic first;
      logic step;
      logic store;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic div_done;
      logic idx_zero;
      logic idx_last;
      logic out_free;
   } status_type;

   localparam logic [4:0] RADIX_MIN = 5'd2;
   localparam logic [4:0] RADIX_MAX = 5'd16;
   localparam logic [3:0] DIV_LAST  = 4'd15;
   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_MINUS = 8'h40;
   localparam logic [7:0] SEG_DOT   = 8'h80;

   function automatic logic [7:0] seg_glyph(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'h0: seg = 8'h3F;
         4'h1: seg = 8'h06;
         4'h2: seg = 8'h5B;
         4'h3: seg = 8'h4F;
         4'h4: seg = 8'h66;
         4'h5: seg = 8'h6D;
         4'h6: seg = 8'h7D;
         4'h7: seg = 8'h07;
         4'h8: seg = 8'h7F;
         4'h9: seg = 8'h6F;
         4'hA: seg = 8'h77;
         4'hB: seg = 8'h7C;
         4'hC: seg = 8'h39;
         4'hD: seg = 8'h5E;
         4'hE: seg = 8'h79;
         default: seg = 8'h71;
      endcase
      return seg;
   endfunction

endpackage

// ===== hw/rtl/nts_ctrl.sv =====
// nts_ctrl: sequencer for load, per-digit division, digit store and beat emission
// depends on nts_pkg
module nts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  nts_pkg::status_type status,
   output nts_pkg::cmd_type    cmd
);
   import nts_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.len_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.first = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.idx_zero ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/nts_dpath.sv =====
// nts_dpath: operand registers, bit-serial radix divider, digit buffer and output register
// depends on nts_pkg
module nts_dpath #(
   parameter int DISPLAY_DIGITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  nts_pkg::req_type    req_payload,
   input  nts_pkg::cmd_type    cmd,
   output nts_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nts_pkg::rsp_type    rsp_payload
);
   import nts_pkg::*;

   localparam int IDX_W = (DISPLAY_DIGITS > 1) ? $clog2(DISPLAY_DIGITS) : 1;
   localparam logic [3:0] DIGITS = 4'(DISPLAY_DIGITS);

   logic [15:0] num_ff;
   logic [4:0]  base_ff;
   logic        neg_ff;
   logic        lz_ff;
   logic        zero_ff;
   logic [7:0]  dots_ff;
   logic [2:0]  len_ff;
   logic [1:0]  start_ff;
   logic [3:0]  rem_ff;
   logic [3:0]  cnt_ff;
   logic [2:0]  idx_ff;
   logic [7:0]  segs_ff [DISPLAY_DIGITS];
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [4:0]  base_c;
   logic [3:0]  start_c;
   logic [3:0]  room;
   logic [3:0]  len_c;
   logic [4:0]  shifted;
   logic        fits;
   logic [3:0]  rem_in;
   logic        digit_zero;
   logic [7:0]  seg_in;
   logic [2:0]  last_idx;

   // operand clamping at load
   always_comb begin
      if (req_payload.radix < RADIX_MIN) begin
         base_c = RADIX_MIN;
      end else if (req_payload.radix > RADIX_MAX) begin
         base_c = RADIX_MAX;
      end else begin
         base_c = req_payload.radix;
      end
      start_c = {2'b00, req_payload.start_position};
      if (start_c >= DIGITS) begin
         start_c = DIGITS - 4'd1;
      end
      room  = DIGITS - start_c;
      len_c = {1'b0, req_payload.field_length};
      if (len_c > room) begin
         len_c = room;
      end
   end

   // one restoring division step
   assign shifted = {rem_ff, num_ff[15]};
   assign fits    = (shifted >= base_ff);
   always_comb begin
      if (fits) begin
         rem_in = 4'(shifted - base_ff);
      end else begin
         rem_in = shifted[3:0];
      end
   end

   assign last_idx   = len_ff - 3'd1;
   assign digit_zero = (rem_ff == 4'd0) && (num_ff == 16'd0);

   always_comb begin
      if (zero_ff) begin
         seg_in = (idx_ff == last_idx) ? seg_glyph(4'd0) : SEG_BLANK;
      end else if (digit_zero && neg_ff) begin
         seg_in = SEG_MINUS;
      end else if (digit_zero && !lz_ff) begin
         seg_in = SEG_BLANK;
      end else begin
         seg_in = seg_glyph(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff   <= req_payload.magnitude;
         base_ff  <= base_c;
         neg_ff   <= req_payload.is_negative;
         lz_ff    <= req_payload.show_leading_zeros;
         zero_ff  <= (req_payload.magnitude == 16'd0) && !req_payload.show_leading_zeros;
         dots_ff  <= req_payload.dot_mask;
         len_ff   <= len_c[2:0];
         start_ff <= start_c[1:0];
      end
      if (cmd.first) begin
         rem_ff <= 4'd0;
         cnt_ff <= 4'd0;
         idx_ff <= last_idx;
      end
      if (cmd.step) begin
         num_ff <= {num_ff[14:0], fits};
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (cmd.store) begin
         segs_ff[idx_ff[IDX_W-1:0]] <= seg_in;
         if (digit_zero && neg_ff && !zero_ff) begin
            neg_ff <= 1'b0;
         end
         rem_ff <= 4'd0;
         cnt_ff <= 4'd0;
         if (idx_ff != 3'd0) begin
            idx_ff <= idx_ff - 3'd1;
         end
      end
      if (cmd.emit) begin
         rsp_ff.position <= start_ff + idx_ff[1:0];
         rsp_ff.segments <= segs_ff[idx_ff[IDX_W-1:0]]
                            | (dots_ff[3'd7 - idx_ff] ? SEG_DOT : SEG_BLANK);
         rsp_ff.last     <= (idx_ff == last_idx);
         idx_ff          <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.len_zero = (len_ff == 3'd0);
   assign status.div_done = (cnt_ff == DIV_LAST);
   assign status.idx_zero = (idx_ff == 3'd0);
   assign status.idx_last = (idx_ff == last_idx);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hw/rtl/number_to_seven_segment.sv =====
// number_to_seven_segment: top level, formats a 16-bit magnitude as seven-segment beats
// depends on nts_pkg, nts_ctrl, nts_dpath
//
// Takes one request beat (magnitude, radix, sign, leading-zero flag, dot mask,
// field length, start position) and returns one response beat per field
// position, leftmost first, with last set on the rightmost one. Radix is
// clamped to 2..16, start to DISPLAY_DIGITS-1 and the length to the room left
// on the display; a length of zero gives no beats. Digits are found right to
// left by a bit-serial restoring divider, each digit followed by a store
// step; once all are stored, the beats go out one per cycle while rsp_ready
// is high. One request is in work at a time; a new one is taken once the final
// beat is registered.
module number_to_seven_segment #(
   parameter int DISPLAY_DIGITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  nts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output nts_pkg::rsp_type rsp_payload
);
   import nts_pkg::*;

   cmd_type    cmd;
   status_type status;

   nts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nts_dpath #(
      .DISPLAY_DIGITS (DISPLAY_DIGITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/number_to_seven_segment_test.sv =====
`timescale 1ns / 100ps
// number_to_seven_segment_test: self-checking testbench for number_to_seven_segment
// with its own beat predictor, random request and response stalls and one long
// response hold-off; depends on nts_pkg and number_to_seven_segment
module number_to_seven_segment_test;
   import nts_pkg::*;

   localparam int DISPLAY_DIGITS = 4;
   localparam int RANDOM_REQS = 405;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 100;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type     pending_reqs[$];
   rsp_type     expected_beats[$];
   int unsigned total_reqs = 0;
   int unsigned reqs_taken = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_wait = 0;
   int unsigned recv_wait = 0;
   bit          send_idle = 1'b1;
   bit          recv_idle = 1'b1;
   logic        rsp_hold = 1'b0;

   number_to_seven_segment #(
      .DISPLAY_DIGITS(DISPLAY_DIGITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   function automatic logic [7:0] digit_pattern(input int unsigned digit);
      logic [7:0] pattern;
      case (digit)
         0: pattern = 8'b0011_1111;
         1: pattern = 8'b0000_0110;
         2: pattern = 8'b0101_1011;
         3: pattern = 8'b0100_1111;
         4: pattern = 8'b0110_0110;
         5: pattern = 8'b0110_1101;
         6: pattern = 8'b0111_1101;
         7: pattern = 8'b0000_0111;
         8: pattern = 8'b0111_1111;
         9: pattern = 8'b0110_1111;
         10: pattern = 8'b0111_0111;
         11: pattern = 8'b0111_1100;
         12: pattern = 8'b0011_1001;
         13: pattern = 8'b0101_1110;
         14: pattern = 8'b0111_1001;
         default: pattern = 8'b0111_0001;
      endcase
      return pattern;
   endfunction

   // digits right to left, then one beat per position left to right
   function automatic void format_field(input req_type r);
      logic [7:0]  cells [0:DISPLAY_DIGITS-1];
      logic [7:0]  seg;
      rsp_type     beat;
      int unsigned value, base, first, len, digit, k;
      bit          minus_open;
      base = r.radix;
      if (base < RADIX_MIN) base = RADIX_MIN;
      if (base > RADIX_MAX) base = RADIX_MAX;
      first = r.start_position;
      if (first >= DISPLAY_DIGITS) first = DISPLAY_DIGITS - 1;
      len = r.field_length;
      if (len > DISPLAY_DIGITS - first) len = DISPLAY_DIGITS - first;
      if (len == 0) return;
      for (k = 0; k < DISPLAY_DIGITS; k++) cells[k] = SEG_BLANK;
      value = r.magnitude;
      minus_open = r.is_negative;
      if (value == 0 && !r.show_leading_zeros) begin
         cells[len - 1] = digit_pattern(0);
      end else begin
         for (k = len; k > 0; k--) begin
            digit = value % base;
            if (digit == 0 && value == 0 && !r.show_leading_zeros) cells[k - 1] = SEG_BLANK;
            else cells[k - 1] = digit_pattern(digit);
            if (digit == 0 && value == 0 && minus_open) begin
               cells[k - 1] = SEG_MINUS;
               minus_open = 1'b0;
            end
            value = value / base;
         end
      end
      for (k = 0; k < len; k++) begin
         seg = cells[k];
         if (r.dot_mask[7 - (k % 8)]) seg = seg | SEG_DOT;
         beat.position = 2'((first + k) % 4);
         beat.segments = seg;
         beat.last = (k + 1 == len);
         expected_beats.push_back(beat);
      end
   endfunction

   function automatic int unsigned pick_gap(input bit idle);
      return idle ? $urandom_range(0, 14) : 0;
   endfunction

   task automatic add_req(input int unsigned mag, input int unsigned radix, input bit neg,
                          input bit lz, input int unsigned dots, input int unsigned len,
                          input int unsigned start);
      req_type r;
      r.magnitude = 16'(mag);
      r.radix = 5'(radix);
      r.is_negative = neg;
      r.show_leading_zeros = lz;
      r.dot_mask = 8'(dots);
      r.field_length = 3'(len);
      r.start_position = 2'(start);
      pending_reqs.push_back(r);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) begin
            format_field(req_payload);
            reqs_taken <= reqs_taken + 1;
         end
         if (send_wait != 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_payload <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            send_wait <= pick_gap(send_idle);
            if ($urandom_range(0, 29) == 0) send_idle <= !send_idle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(posedge clock) begin : receive_side
      rsp_type     want;
      int unsigned wait_next;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         wait_next = recv_wait;
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("unexpected beat: pos %0d seg %h last %b",
                           rsp_payload.position, rsp_payload.segments, rsp_payload.last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_payload.position !== want.position ||
                   rsp_payload.segments !== want.segments ||
                   rsp_payload.last !== want.last) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("expected pos %0d seg %h last %b, got pos %0d seg %h last %b",
                              want.position, want.segments, want.last,
                              rsp_payload.position, rsp_payload.segments, rsp_payload.last);
               end
            end
            wait_next = pick_gap(recv_idle);
            if ($urandom_range(0, 29) == 0) recv_idle <= !recv_idle;
         end else if (wait_next != 0) begin
            wait_next = wait_next - 1;
         end
         recv_wait <= wait_next;
         rsp_ready <= (wait_next == 0) && !rsp_hold;
      end
   end

   // long response hold-off so the block backs up into its input
   initial begin
      while (reqs_taken < 80) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      req_type     r;
      int unsigned counted;
      // zero, sign and leading-zero handling
      add_req(0, 10, 0, 0, 8'h00, 4, 0);
      add_req(0, 10, 1, 0, 8'h00, 4, 0);
      add_req(0, 10, 1, 1, 8'h00, 4, 0);
      add_req(0, 16, 0, 1, 8'hFF, 4, 0);
      add_req(42, 10, 1, 0, 8'h00, 4, 0);
      add_req(42, 10, 1, 1, 8'h00, 4, 0);
      add_req(1234, 10, 1, 0, 8'h40, 4, 0);
      add_req(7, 10, 1, 0, 8'h00, 1, 3);
      // magnitude extremes, digits dropped past the field
      add_req(65535, 16, 0, 0, 8'h80, 4, 0);
      add_req(65535, 10, 0, 0, 8'h01, 4, 0);
      add_req(65535, 2, 1, 1, 8'hAA, 4, 0);
      add_req(16'h8000, 16, 0, 0, 8'h55, 4, 0);
      // radix clamping and odd bases
      add_req(255, 0, 0, 0, 8'h00, 4, 0);
      add_req(255, 1, 0, 1, 8'h00, 4, 0);
      add_req(255, 17, 0, 0, 8'h00, 4, 0);
      add_req(54321, 31, 1, 0, 8'h00, 4, 0);
      add_req(100, 3, 0, 0, 8'h00, 4, 0);
      add_req(99, 7, 1, 0, 8'h00, 4, 0);
      // length clamping and empty field
      add_req(5678, 10, 0, 0, 8'hF0, 4, 3);
      add_req(5678, 10, 0, 0, 8'h0F, 7, 2);
      add_req(89, 10, 1, 0, 8'h00, 5, 0);
      add_req(89, 10, 0, 1, 8'h00, 6, 1);
      add_req(123, 10, 0, 0, 8'hFF, 0, 0);
      add_req(12, 16, 1, 0, 8'h20, 2, 1);
      counted = 0;
      while (counted < RANDOM_REQS) begin
         case ($urandom_range(0, 2))
            0: r.magnitude = 16'($urandom_range(0, 65535));
            1: r.magnitude = 16'($urandom_range(0, 255));
            default: r.magnitude = 16'($urandom_range(0, 20));
         endcase
         if ($urandom_range(0, 9) == 0) r.radix = 5'($urandom_range(0, 31));
         else r.radix = 5'($urandom_range(2, 16));
         if ($urandom_range(0, 9) == 0) r.field_length = 3'($urandom_range(0, 7));
         else r.field_length = 3'($urandom_range(1, 4));
         r.is_negative = 1'($urandom_range(0, 1));
         r.show_leading_zeros = 1'($urandom_range(0, 1));
         r.dot_mask = 8'($urandom_range(0, 255));
         r.start_position = 2'($urandom_range(0, 3));
         pending_reqs.push_back(r);
         if (r.field_length != 0) counted++;
      end
      total_reqs = pending_reqs.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (reqs_taken != total_reqs) @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
